>>> hw/rtl/srt_pkg.sv
// Shared types and constants of the stereo ray triangulator.
`default_nettype none

package srt_pkg;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } srt_in_t;

  typedef struct packed {
    logic               accepted;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic        [22:0] point_z;
  } srt_out_t;

  typedef enum logic [2:0] {
    REG_ROT_ROW0   = 3'd0,
    REG_ROT_ROW1   = 3'd1,
    REG_ROT_ROW2   = 3'd2,
    REG_TRANS      = 3'd3,
    REG_MIN_DEPTH  = 3'd4,
    REG_MAX_DEPTH  = 3'd5,
    REG_MIN_RDEPTH = 3'd6,
    REG_MAX_ERR    = 3'd7
  } srt_reg_t;

  localparam logic [47:0] ROT_ROW0_RST   = 48'd16384;
  localparam logic [47:0] ROT_ROW1_RST   = 48'd1073741824;
  localparam logic [47:0] ROT_ROW2_RST   = 48'd70368744177664;
  localparam logic [22:0] MIN_DEPTH_RST  = 23'd819;
  localparam logic [22:0] MAX_DEPTH_RST  = 23'd327680;
  localparam logic [22:0] MIN_RDEPTH_RST = 23'd410;
  localparam logic [14:0] MAX_ERR_RST    = 15'd410;

  // divider: quotient bits per item, numerator and divisor widths
  localparam int DIV_STEPS = 23;
  localparam int DIV_NUM_W = 72;
  localparam int DIV_DEN_W = 58;
  localparam int DIV_LAT   = DIV_STEPS + 1;

endpackage

`default_nettype wire

>>> hw/rtl/srt_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none

module srt_divider import srt_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_STEPS-1:0] quo,
  output logic                 ovf
);

  localparam int RemW  = DIV_DEN_W;
  localparam int HeadW = DIV_NUM_W - DIV_STEPS;

  logic [RemW-1:0]      rem_r   [DIV_LAT];
  logic [DIV_STEPS-1:0] low_r   [DIV_LAT];
  logic [DIV_STEPS-1:0] quo_r   [DIV_LAT];
  logic [RemW-1:0]      den_r   [DIV_LAT];
  logic                 ovf_r   [DIV_LAT];
  logic [RemW-1:0]      rem_nxt [DIV_LAT];
  logic [DIV_STEPS-1:0] low_nxt [DIV_LAT];
  logic [DIV_STEPS-1:0] quo_nxt [DIV_LAT];
  logic [RemW-1:0]      den_nxt [DIV_LAT];
  logic                 ovf_nxt [DIV_LAT];
  logic [RemW:0]        trial   [1:DIV_STEPS];
  logic                 ge      [1:DIV_STEPS];

  always_comb begin
    // head of the numerator must stay below the divisor, else quotient overflows
    rem_nxt[0] = {{(RemW-HeadW){1'b0}}, num[DIV_NUM_W-1:DIV_STEPS]};
    low_nxt[0] = num[DIV_STEPS-1:0];
    quo_nxt[0] = '0;
    den_nxt[0] = den;
    ovf_nxt[0] = {{(RemW-HeadW){1'b0}}, num[DIV_NUM_W-1:DIV_STEPS]} >= den;
    for (int s = 1; s < DIV_LAT; s++) begin
      trial[s]   = {rem_r[s-1], low_r[s-1][DIV_STEPS-1]};
      ge[s]      = trial[s] >= {1'b0, den_r[s-1]};
      rem_nxt[s] = ge[s] ? RemW'(trial[s] - {1'b0, den_r[s-1]}) : trial[s][RemW-1:0];
      low_nxt[s] = {low_r[s-1][DIV_STEPS-2:0], 1'b0};
      quo_nxt[s] = {quo_r[s-1][DIV_STEPS-2:0], ge[s]};
      den_nxt[s] = den_r[s-1];
      ovf_nxt[s] = ovf_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_LAT; s++) begin
      rem_r[s] <= rem_nxt[s];
      low_r[s] <= low_nxt[s];
      quo_r[s] <= quo_nxt[s];
      den_r[s] <= den_nxt[s];
      ovf_r[s] <= ovf_nxt[s];
    end
  end

  assign quo = quo_r[DIV_STEPS];
  assign ovf = ovf_r[DIV_STEPS];

endmodule

`default_nettype wire

>>> hw/rtl/stereo_ray_triangulator_unit.sv
// Stereo ray triangulator: fixed-point least-squares depth of a matched pair.
// One pair per cycle from start to out_valid; busy stays low.
// Most of the latency is the two 24-stage divider banks in series (depth/lambda,
// then projection); all stages are pipelined, so throughput stays one pair per cycle.
// Synchronous active-low reset: config registers to defaults, pipeline flushed,
// busy high during reset and for one cycle after it.
`default_nettype none

module stereo_ray_triangulator_unit import srt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  srt_in_t     in_data,
  output logic        out_valid,
  output srt_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int DIV1_IN  = 8;
  localparam int DIV1_OUT = DIV1_IN + DIV_LAT;
  localparam int MUL_ST   = DIV1_OUT + 1;
  localparam int DIV2_IN  = MUL_ST + 1;
  localparam int DIV2_OUT = DIV2_IN + DIV_LAT;
  localparam int ERR_ST   = DIV2_OUT + 1;
  localparam int SQ_ST    = ERR_ST + 1;
  localparam int PIPE_LAT = SQ_ST + 1;

  typedef struct packed {
    logic den_nz;
    logic dsign;
    logic lsign;
  } head_t;

  typedef struct packed {
    logic               ok;
    logic               sx;
    logic               sy;
    logic signed [23:0] pt_x;
    logic signed [23:0] pt_y;
    logic        [22:0] z;
  } tail_t;

  // config
  logic [47:0] rot_r [3];
  logic [47:0] trans_r;
  logic [22:0] min_depth_r, max_depth_r, min_rdepth_r;
  logic [14:0] max_err_r;
  logic [29:0] thr_sq_r;
  logic        busy_r;
  logic        in_fire;

  logic signed [15:0] rot_e   [3][3];
  logic signed [15:0] trans_e [3];

  // pipeline
  logic          vld_r [1:SQ_ST];
  srt_in_t       it_d  [1:ERR_ST-1];
  logic signed [31:0] pr_nxt [3][2];
  logic signed [31:0] pr_r   [3][2];
  logic signed [33:0] v1_nxt [3];
  logic signed [33:0] v1_d   [3:DIV1_OUT][3];
  logic signed [15:0] v2_e   [3];
  logic signed [49:0] c1_nxt [3], c2_nxt [3], d1_nxt [3], d2_nxt [3];
  logic signed [49:0] c1_r   [3], c2_r   [3], d1_r   [3], d2_r   [3];
  logic signed [32:0] w_nxt  [3];
  logic signed [32:0] w4_r   [3];
  logic signed [32:0] w5_r   [3];
  logic signed [28:0] n_nxt  [3], m_nxt [3];
  logic signed [28:0] n_r    [3], m_r   [3];
  logic signed [57:0] nn_r   [3], nm_r  [3];
  logic signed [61:0] nw_r   [3];
  logic        [57:0] den_nxt;
  logic        [57:0] den7_r, den8_r;
  logic signed [63:0] dnum_nxt, dnum_r, dmag;
  logic signed [59:0] lnum_nxt, lnum_r, lmag;
  logic [DIV_NUM_W-1:0] dn_num_r, ln_num_r;
  head_t         hd_d [DIV1_IN:DIV1_OUT];

  logic [DIV_STEPS-1:0] dq, lq;
  logic                 dovf, lovf;
  logic                 dneg, depth_ok, lam_ok;

  logic                 ok33_r;
  logic        [22:0]   z33_r;
  logic signed [57:0]   pp_r [3];
  logic signed [39:0]   px33_r, py33_r;
  logic signed [57:0]   p_nxt [3];
  logic        [57:0]   pxm, pym;
  logic                 pz_ok;
  logic [DIV_NUM_W-1:0] ux_num_r, uy_num_r;
  logic [DIV_DEN_W-1:0] pz_r;
  tail_t                tl_nxt;
  tail_t                tl_d [DIV2_IN:SQ_ST];

  logic [DIV_STEPS-1:0] xq, yq;
  logic                 xovf, yovf;
  logic signed [21:0]   ux, uy;
  logic signed [22:0]   ex_r, ey_r;
  logic        [45:0]   sqx_r, sqy_r;
  logic        [46:0]   err_sq;
  logic                 out_valid_r;
  srt_out_t             out_data_r, out_nxt;

  function automatic logic signed [28:0] rnd_sh20(input logic signed [50:0] x);
    logic [50:0] mag;
    logic [50:0] q;
    mag = x[50] ? 51'(-x) : 51'(x);
    q = (mag + 51'd524288) >> 20;
    rnd_sh20 = x[50] ? -$signed(q[28:0]) : $signed(q[28:0]);
  endfunction

  function automatic logic signed [23:0] rnd_sat(input logic signed [39:0] x);
    logic [39:0] mag;
    logic [39:0] q;
    mag = x[39] ? 40'(-x) : 40'(x);
    q = (mag + 40'd4096) >> 13;
    if (!x[39]) begin
      rnd_sat = (q > 40'd8388607) ? 24'sh7FFFFF : $signed(q[23:0]);
    end else begin
      rnd_sat = (q > 40'd8388608) ? 24'sh800000 : -$signed(q[23:0]);
    end
  endfunction

  function automatic logic signed [21:0] proj_val(input logic neg, input logic [22:0] q,
                                                  input logic of);
    logic [21:0] v;
    v = (of || q > 23'd1048576) ? 22'd1048576 : q[21:0];
    proj_val = neg ? -$signed(v) : $signed(v);
  endfunction

  assign in_fire   = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]     <= ROT_ROW0_RST;
      rot_r[1]     <= ROT_ROW1_RST;
      rot_r[2]     <= ROT_ROW2_RST;
      trans_r      <= '0;
      min_depth_r  <= MIN_DEPTH_RST;
      max_depth_r  <= MAX_DEPTH_RST;
      min_rdepth_r <= MIN_RDEPTH_RST;
      max_err_r    <= MAX_ERR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (srt_reg_t'(cfg_index))
        REG_ROT_ROW0:   rot_r[0]     <= cfg_data;
        REG_ROT_ROW1:   rot_r[1]     <= cfg_data;
        REG_ROT_ROW2:   rot_r[2]     <= cfg_data;
        REG_TRANS:      trans_r      <= cfg_data;
        REG_MIN_DEPTH:  min_depth_r  <= cfg_data[22:0];
        REG_MAX_DEPTH:  max_depth_r  <= cfg_data[22:0];
        REG_MIN_RDEPTH: min_rdepth_r <= cfg_data[22:0];
        REG_MAX_ERR:    max_err_r    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= max_err_r * max_err_r;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        rot_e[i][k] = $signed(rot_r[i][16*k +: 16]);
      end
      trans_e[i] = $signed(trans_r[16*i +: 16]);
    end
  end

  // valid and item lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= SQ_ST; s++) vld_r[s] <= 1'b0;
    end else begin
      vld_r[1] <= in_fire;
      for (int s = 2; s <= SQ_ST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    it_d[1] <= in_data;
    for (int s = 2; s < ERR_ST; s++) it_d[s] <= it_d[s-1];
  end

  // rotate left ray
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_nxt[i][0] = rot_e[i][0] * it_d[1].left_x;
      pr_nxt[i][1] = rot_e[i][1] * it_d[1].left_y;
      v1_nxt[i] = 34'(pr_r[i][0]) + 34'(pr_r[i][1]) + {{5{rot_e[i][2][15]}}, rot_e[i][2], 13'b0};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr_r[i]    <= pr_nxt[i];
      v1_d[3][i] <= v1_nxt[i];
      for (int s = 4; s <= DIV1_OUT; s++) v1_d[s][i] <= v1_d[s-1][i];
    end
  end

  // cross products
  assign v2_e[0] = it_d[3].right_x;
  assign v2_e[1] = it_d[3].right_y;
  assign v2_e[2] = 16'sd8192;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c1_nxt[i] = v1_d[3][(i == 2) ? 0 : i + 1] * v2_e[(i == 0) ? 2 : i - 1];
      c2_nxt[i] = v1_d[3][(i == 0) ? 2 : i - 1] * v2_e[(i == 2) ? 0 : i + 1];
      d1_nxt[i] = v1_d[3][(i == 2) ? 0 : i + 1] * trans_e[(i == 0) ? 2 : i - 1];
      d2_nxt[i] = v1_d[3][(i == 0) ? 2 : i - 1] * trans_e[(i == 2) ? 0 : i + 1];
      w_nxt[i]  = 33'(v2_e[(i == 2) ? 0 : i + 1] * trans_e[(i == 0) ? 2 : i - 1])
                - 33'(v2_e[(i == 0) ? 2 : i - 1] * trans_e[(i == 2) ? 0 : i + 1]);
      n_nxt[i]  = rnd_sh20(51'(c1_r[i]) - 51'(c2_r[i]));
      m_nxt[i]  = rnd_sh20(51'(d1_r[i]) - 51'(d2_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c1_r[i] <= c1_nxt[i];
      c2_r[i] <= c2_nxt[i];
      d1_r[i] <= d1_nxt[i];
      d2_r[i] <= d2_nxt[i];
      w4_r[i] <= w_nxt[i];
      n_r[i]  <= n_nxt[i];
      m_r[i]  <= m_nxt[i];
      w5_r[i] <= w4_r[i];
      nn_r[i] <= n_r[i] * n_r[i];
      nw_r[i] <= n_r[i] * w5_r[i];
      nm_r[i] <= n_r[i] * m_r[i];
    end
  end

  // normal equations
  always_comb begin
    den_nxt  = 58'(60'(nn_r[0]) + 60'(nn_r[1]) + 60'(nn_r[2]));
    dnum_nxt = 64'(nw_r[0]) + 64'(nw_r[1]) + 64'(nw_r[2]);
    lnum_nxt = 60'(nm_r[0]) + 60'(nm_r[1]) + 60'(nm_r[2]);
    dmag     = dnum_r[63] ? -dnum_r : dnum_r;
    lmag     = lnum_r[59] ? -lnum_r : lnum_r;
  end

  always_ff @(posedge clk) begin
    den7_r   <= den_nxt;
    dnum_r   <= dnum_nxt;
    lnum_r   <= lnum_nxt;
    den8_r   <= den7_r;
    dn_num_r <= {6'b0, dmag[59:0], 6'b0};
    ln_num_r <= {2'b0, lmag[57:0], 12'b0};
    hd_d[DIV1_IN] <= '{den_nz: den7_r != '0, dsign: dnum_r[63], lsign: lnum_r[59]};
    for (int s = DIV1_IN + 1; s <= DIV1_OUT; s++) hd_d[s] <= hd_d[s-1];
  end

  srt_divider u_div_depth (
    .clk (clk),
    .num (dn_num_r),
    .den (den8_r),
    .quo (dq),
    .ovf (dovf)
  );

  srt_divider u_div_lambda (
    .clk (clk),
    .num (ln_num_r),
    .den (den8_r),
    .quo (lq),
    .ovf (lovf)
  );

  // depth checks, reprojection products
  always_comb begin
    dneg     = hd_d[DIV1_OUT].dsign && (dq != '0);
    depth_ok = !dneg && !dovf && dq >= min_depth_r && dq <= max_depth_r;
    if (lovf) begin
      lam_ok = !hd_d[DIV1_OUT].lsign;
    end else if (hd_d[DIV1_OUT].lsign && lq != '0) begin
      lam_ok = 1'b0;
    end else begin
      lam_ok = lq >= min_rdepth_r;
    end
  end

  always_ff @(posedge clk) begin
    ok33_r <= hd_d[DIV1_OUT].den_nz && depth_ok && lam_ok;
    z33_r  <= dq;
    for (int i = 0; i < 3; i++) begin
      pp_r[i] <= $signed({1'b0, dq}) * v1_d[DIV1_OUT][i];
    end
    px33_r <= it_d[DIV1_OUT].left_x * $signed({1'b0, dq});
    py33_r <= it_d[DIV1_OUT].left_y * $signed({1'b0, dq});
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = pp_r[i] + {{16{trans_e[i][15]}}, trans_e[i], 26'b0};
    end
    pz_ok = !p_nxt[2][57] && (p_nxt[2] != '0)
            && (p_nxt[2][56:0] >= {7'b0, min_rdepth_r, 27'b0});
    pxm   = p_nxt[0][57] ? 58'(-p_nxt[0]) : 58'(p_nxt[0]);
    pym   = p_nxt[1][57] ? 58'(-p_nxt[1]) : 58'(p_nxt[1]);
    tl_nxt.ok   = ok33_r && pz_ok;
    tl_nxt.sx   = p_nxt[0][57];
    tl_nxt.sy   = p_nxt[1][57];
    tl_nxt.pt_x = rnd_sat(px33_r);
    tl_nxt.pt_y = rnd_sat(py33_r);
    tl_nxt.z    = z33_r;
  end

  always_ff @(posedge clk) begin
    ux_num_r <= {2'b0, pxm[56:0], 13'b0};
    uy_num_r <= {2'b0, pym[56:0], 13'b0};
    pz_r     <= p_nxt[2];
    tl_d[DIV2_IN] <= tl_nxt;
    for (int s = DIV2_IN + 1; s <= SQ_ST; s++) tl_d[s] <= tl_d[s-1];
  end

  srt_divider u_div_px (
    .clk (clk),
    .num (ux_num_r),
    .den (pz_r),
    .quo (xq),
    .ovf (xovf)
  );

  srt_divider u_div_py (
    .clk (clk),
    .num (uy_num_r),
    .den (pz_r),
    .quo (yq),
    .ovf (yovf)
  );

  // reprojection error
  assign ux = proj_val(tl_d[DIV2_OUT].sx, xq, xovf);
  assign uy = proj_val(tl_d[DIV2_OUT].sy, yq, yovf);

  always_ff @(posedge clk) begin
    ex_r  <= 23'(ux) - 23'(it_d[DIV2_OUT].right_x);
    ey_r  <= 23'(uy) - 23'(it_d[DIV2_OUT].right_y);
    sqx_r <= 46'(ex_r * ex_r);
    sqy_r <= 46'(ey_r * ey_r);
  end

  assign err_sq = 47'(sqx_r) + 47'(sqy_r);

  always_comb begin
    out_nxt = '0;
    if (tl_d[SQ_ST].ok && err_sq <= 47'(thr_sq_r)) begin
      out_nxt.accepted = 1'b1;
      out_nxt.point_x  = tl_d[SQ_ST].pt_x;
      out_nxt.point_y  = tl_d[SQ_ST].pt_y;
      out_nxt.point_z  = tl_d[SQ_ST].z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[SQ_ST];
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every transfer in gives exactly one result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, PIPE_LAT))
    else $error("result strobe out of step with accepted items");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0)
    else $error("rejected point carries nonzero coordinates");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |->
      out_data.point_z >= min_depth_r && out_data.point_z <= max_depth_r)
    else $error("accepted depth outside configured limits");

endmodule

`default_nettype wire

>>> tb/stereo_ray_triangulator_unit_tb.sv
// Self-checking testbench of the stereo ray triangulator: directed table, then random pairs.
`timescale 1ns / 100ps
`default_nettype none

module stereo_ray_triangulator_unit_tb;
  import srt_pkg::*;

  localparam int LATENCY  = 61;
  localparam int WDOG_MAX = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  srt_in_t     in_data = '0;
  logic        out_valid;
  srt_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  stereo_ray_triangulator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block's registers
  logic [47:0] rot [3];
  logic [47:0] trans;
  logic [22:0] dmin, dmax, rdmin;
  logic [14:0] emax;

  srt_out_t points_due[$];
  int       mismatches = 0;
  int       n_pairs = 0;
  int       n_points = 0;
  int       n_accepted = 0;
  int       wdog = 0;
  int       send_idle = 0;

  function automatic longint sx16(logic [47:0] r, int k);
    logic [15:0] v;
    v = r[16*k +: 16];
    return longint'($signed(v));
  endfunction

  function automatic longint round_shift(longint x, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (x >= 0) return (x + half) >>> s;
    return -((-x + half) >>> s);
  endfunction

  function automatic longint cap_div(longint num, longint den, int shift, longint cap);
    longint a, q, r;
    a = (num < 0) ? -num : num;
    q = a / den;
    r = a % den;
    if (q > cap) q = cap;
    for (int i = 0; i < shift && q < cap; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
      if (q > cap) q = cap;
    end
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip24(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  function automatic srt_out_t triangulate(srt_in_t p);
    longint u[3], v1[3], v2[3], t[3], n[3], m[3], w[3], pp[3];
    longint den, dnum, lnum, depth, lambda, ux, uy, ex, ey, e;
    srt_out_t o;
    int a, b;
    o = '0;
    u[0] = longint'(p.left_x); u[1] = longint'(p.left_y); u[2] = 8192;
    v2[0] = longint'(p.right_x); v2[1] = longint'(p.right_y); v2[2] = 8192;
    for (int i = 0; i < 3; i++) begin
      v1[i] = 0;
      for (int k = 0; k < 3; k++) v1[i] += sx16(rot[i], k) * u[k];
      t[i] = sx16(trans, i);
    end
    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      b = (i + 2) % 3;
      n[i] = round_shift(v1[a] * v2[b] - v1[b] * v2[a], 20);
      m[i] = round_shift(v1[a] * t[b] - v1[b] * t[a], 20);
      w[i] = v2[a] * t[b] - v2[b] * t[a];
    end
    den  = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    dnum = n[0] * w[0] + n[1] * w[1] + n[2] * w[2];
    lnum = n[0] * m[0] + n[1] * m[1] + n[2] * m[2];
    if (den <= 0) return o;
    depth  = cap_div(dnum, den, 6, longint'(1) <<< 40);
    lambda = cap_div(lnum, den, 12, longint'(1) <<< 40);
    if (depth < longint'(dmin) || depth > longint'(dmax)) return o;
    if (lambda < longint'(rdmin)) return o;
    for (int i = 0; i < 3; i++) pp[i] = depth * v1[i] + t[i] * 67108864;
    if (pp[2] <= 0 || pp[2] < longint'(rdmin) * 134217728) return o;
    ux = cap_div(pp[0], pp[2], 13, longint'(1) <<< 20);
    uy = cap_div(pp[1], pp[2], 13, longint'(1) <<< 20);
    ex = ux - longint'(p.right_x);
    ey = uy - longint'(p.right_y);
    e = longint'(emax);
    if (ex * ex + ey * ey > e * e) return o;
    o.accepted = 1'b1;
    o.point_x = 24'(clip24(round_shift(longint'(p.left_x) * depth, 13)));
    o.point_y = 24'(clip24(round_shift(longint'(p.left_y) * depth, 13)));
    o.point_z = depth[22:0];
    return o;
  endfunction

  task automatic tick();
    @(posedge clk);
    wdog++;
    if (wdog >= WDOG_MAX) begin
      $display("timeout: no transfer for %0d cycles", WDOG_MAX);
      $display("stereo_ray_triangulator_unit_tb failed");
      $finish;
    end
  endtask

  task automatic write_reg(srt_reg_t idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do tick(); while (!cfg_ready);
    wdog = 0;
    cfg_valid <= 1'b0;
    tick();
    case (idx)
      REG_ROT_ROW0:   rot[0] = val;
      REG_ROT_ROW1:   rot[1] = val;
      REG_ROT_ROW2:   rot[2] = val;
      REG_TRANS:      trans = val;
      REG_MIN_DEPTH:  dmin = val[22:0];
      REG_MAX_DEPTH:  dmax = val[22:0];
      REG_MIN_RDEPTH: rdmin = val[22:0];
      default:        emax = val[14:0];
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (points_due.size() > 0) tick();
    repeat (LATENCY + 4) tick();
  endtask

  // one transfer; start stays high across back-to-back transfers
  task automatic send_pair(srt_in_t p, bit check_typed, srt_out_t typed);
    while ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      tick();
    end
    start   <= 1'b1;
    in_data <= p;
    do tick(); while (busy);
    wdog = 0;
    points_due.insert(points_due.size(), check_typed ? typed : triangulate(p));
    n_pairs++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      wdog = 0;
      n_points++;
      if (out_data.accepted) n_accepted++;
      if (points_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        srt_out_t exp_pt;
        exp_pt = points_due.pop_front();
        if (out_data !== exp_pt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp acc=%0b x=%0d y=%0d z=%0d  got acc=%0b x=%0d y=%0d z=%0d",
                     exp_pt.accepted, exp_pt.point_x, exp_pt.point_y, exp_pt.point_z,
                     out_data.accepted, out_data.point_x, out_data.point_y,
                     out_data.point_z);
        end
      end
    end
  end

  function automatic logic [47:0] pack3(int a, int b, int c);
    logic [15:0] ea, eb, ec;
    ea = a[15:0]; eb = b[15:0]; ec = c[15:0];
    return {ec, eb, ea};
  endfunction

  // left ray pushed through the current setup to a point at a given depth
  function automatic srt_in_t good_pair(int lx, int ly, int zq);
    srt_in_t p;
    longint px, py, pz;
    p.left_x = lx[15:0];
    p.left_y = ly[15:0];
    px = (sx16(rot[0], 0) * lx + sx16(rot[0], 1) * ly + sx16(rot[0], 2) * 8192) * zq
         / 134217728 + sx16(trans, 0) / 2;
    py = (sx16(rot[1], 0) * lx + sx16(rot[1], 1) * ly + sx16(rot[1], 2) * 8192) * zq
         / 134217728 + sx16(trans, 1) / 2;
    pz = (sx16(rot[2], 0) * lx + sx16(rot[2], 1) * ly + sx16(rot[2], 2) * 8192) * zq
         / 134217728 + sx16(trans, 2) / 2;
    if (pz <= 0) pz = 1;
    px = px * 8192 / pz;
    py = py * 8192 / pz;
    if (px > 32767) px = 32767;
    if (px < -32768) px = -32768;
    if (py > 32767) py = 32767;
    if (py < -32768) py = -32768;
    p.right_x = 16'(px + $signed($urandom_range(6)) - 3);
    p.right_y = 16'(py + $signed($urandom_range(6)) - 3);
    return p;
  endfunction

  task automatic random_phase(int count);
    srt_in_t p;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 25) p = srt_in_t'({$urandom, $urandom});
      else p = good_pair($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                         $urandom_range(200000) + 500);
      send_pair(p, 1'b0, '0);
    end
  endtask

  typedef struct {
    srt_in_t  pair;
    bit       typed;
    srt_out_t result;
  } stim_row_t;

  stim_row_t rows[$];

  function automatic void add_row(srt_in_t pair, bit typed, srt_out_t result);
    stim_row_t r;
    r.pair   = pair;
    r.typed  = typed;
    r.result = result;
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    rot[0] = ROT_ROW0_RST; rot[1] = ROT_ROW1_RST; rot[2] = ROT_ROW2_RST;
    trans = '0; dmin = MIN_DEPTH_RST; dmax = MAX_DEPTH_RST;
    rdmin = MIN_RDEPTH_RST; emax = MAX_ERR_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero translation: every pair is degenerate or has zero depth
    add_row(srt_in_t'(64'h0), 1'b1, srt_out_t'('0));
    add_row(srt_in_t'({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}), 1'b1, '0);
    add_row(srt_in_t'({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000}), 1'b1, '0);
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].result);
    drain();

    // horizontal stereo baseline
    write_reg(REG_TRANS, pack3(-819, 0, 0));
    rows.delete();
    add_row(srt_in_t'(64'h0), 1'b1, '0);
    add_row(srt_in_t'({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}), 1'b0, '0);
    add_row(srt_in_t'({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}), 1'b0, '0);
    add_row(good_pair(1000, -500, 8192 * 5), 1'b0, '0);
    add_row(good_pair(-3000, 2000, 8192 * 2), 1'b0, '0);
    add_row(good_pair(0, 0, 1000), 1'b0, '0);
    add_row(good_pair(200, 100, 8192 * 90), 1'b0, '0);
    add_row(good_pair(500, 500, 8192 * 10), 1'b0, '0);
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].result);
    drain();

    // zero lower limits and zero error threshold; then inverted limits
    write_reg(REG_MIN_RDEPTH, 48'd0);
    write_reg(REG_MAX_ERR, 48'd0);
    write_reg(REG_MIN_DEPTH, 48'd0);
    write_reg(REG_MAX_DEPTH, 48'h7fffff);
    for (int i = 0; i < 6; i++) send_pair(good_pair(800 * i - 2000, 300 * i, 8192 * 4),
                                          1'b0, '0);
    drain();
    write_reg(REG_MIN_DEPTH, 48'd400000);
    write_reg(REG_MAX_DEPTH, 48'd1000);
    send_pair(good_pair(100, 100, 8192 * 3), 1'b1, '0);
    send_pair(good_pair(-100, 50, 8192 * 30), 1'b1, '0);
    drain();

    // random phases, each with its own setup
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 35 : (ph == 1) ? 76 : 0;
      write_reg(REG_ROT_ROW0, pack3(16384 - $urandom_range(300), $urandom_range(600) - 300,
                                    $urandom_range(600) - 300));
      write_reg(REG_ROT_ROW1, pack3($urandom_range(600) - 300, 16384 - $urandom_range(300),
                                    $urandom_range(600) - 300));
      write_reg(REG_ROT_ROW2, pack3($urandom_range(600) - 300, $urandom_range(600) - 300,
                                    16384 - $urandom_range(300)));
      write_reg(REG_TRANS, pack3(-$urandom_range(4000) - 200, $urandom_range(400) - 200,
                                 $urandom_range(400) - 200));
      write_reg(REG_MIN_DEPTH, (ph == 2) ? 48'd0 : 48'($urandom_range(2000)));
      write_reg(REG_MAX_DEPTH, (ph == 2) ? 48'h7fffff : 48'($urandom_range(400000) + 50000));
      write_reg(REG_MIN_RDEPTH, 48'($urandom_range(1000)));
      write_reg(REG_MAX_ERR, (ph == 2) ? 48'h7fff : 48'($urandom_range(600)));
      random_phase(400);
      drain();
    end
    // one phase with a full random rotation, mostly noise
    write_reg(REG_ROT_ROW0, 48'({$urandom, $urandom}));
    write_reg(REG_ROT_ROW1, 48'({$urandom, $urandom}));
    write_reg(REG_ROT_ROW2, 48'({$urandom, $urandom}));
    write_reg(REG_TRANS, 48'({$urandom, $urandom}));
    random_phase(150);
    drain();

    $display("%0d pairs sent over several register setups, %0d results, %0d accepted",
             n_pairs, n_points, n_accepted);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && points_due.size() == 0) begin
      $display("stereo_ray_triangulator_unit_tb passed");
    end else begin
      $display("stereo_ray_triangulator_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
